/* rtl/psd_pkg.sv */
package psd_pkg;

  localparam int CW    = 24;          // coordinate width
  localparam int DW    = CW + 1;      // coordinate difference
  localparam int L2W   = 2 * DW;      // squared length
  localparam int DOTW  = 2 * DW + 1;  // dot product, signed
  localparam int TB    = 32;          // projection fraction bits
  localparam int EW    = CW + 3;      // residual offset, signed
  localparam int SQW   = 2 * EW;      // squared distance
  localparam int DISTW = 25;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } psd_in_t;

  typedef struct packed {
    logic [DISTW-1:0] distance;
    logic             degenerate;
  } psd_out_t;

  // what travels beside the divider
  typedef struct packed {
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
    logic signed [DW-1:0] apx;
    logic signed [DW-1:0] apy;
    logic                 degen;
    logic                 t_zero;
    logic                 t_one;
  } psd_dside_t;

endpackage

/* rtl/psd_div_cell.sv */
module psd_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [psd_pkg::L2W-1:0]   rem_i,
  input  logic [psd_pkg::L2W-1:0]   den_i,
  input  logic [psd_pkg::TB-1:0]    quo_i,
  input  psd_pkg::psd_dside_t       side_i,
  output logic                      vld_o,
  output logic [psd_pkg::L2W-1:0]   rem_o,
  output logic [psd_pkg::L2W-1:0]   den_o,
  output logic [psd_pkg::TB-1:0]    quo_o,
  output psd_pkg::psd_dside_t       side_o
);

  logic [psd_pkg::L2W:0]   rem2;
  logic [psd_pkg::L2W:0]   diff;
  logic                    ge;
  logic                    vld_r;
  logic [psd_pkg::L2W-1:0] rem_r, rem_nxt, den_r;
  logic [psd_pkg::TB-1:0]  quo_r, quo_nxt;
  psd_pkg::psd_dside_t     side_r;

  // one restoring division step
  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, den_i};
    ge      = (rem2 >= {1'b0, den_i});
    rem_nxt = ge ? diff[psd_pkg::L2W-1:0] : rem2[psd_pkg::L2W-1:0];
    quo_nxt = {quo_i[psd_pkg::TB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_i;
    quo_r  <= quo_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

/* rtl/psd_sqrt_cell.sv */
module psd_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic [psd_pkg::SQW-1:0] rad_i,
  input  logic [psd_pkg::SQW-1:0] root_i,
  input  logic                    degen_i,
  output logic                    vld_o,
  output logic [psd_pkg::SQW-1:0] rad_o,
  output logic [psd_pkg::SQW-1:0] root_o,
  output logic                    degen_o
);

  localparam logic [psd_pkg::SQW-1:0] BIT = {{(psd_pkg::SQW-1){1'b0}}, 1'b1} << SHIFT;

  logic [psd_pkg::SQW-1:0] trial;
  logic [psd_pkg::SQW-1:0] rad_nxt, root_nxt, rad_r, root_r;
  logic                    vld_r, degen_r;

  always_comb begin
    trial = root_i + BIT;
    if (rad_i >= trial) begin
      rad_nxt  = rad_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rad_nxt  = rad_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rad_r   <= rad_nxt;
    root_r  <= root_nxt;
    degen_r <= degen_i;
  end

  assign vld_o   = vld_r;
  assign rad_o   = rad_r;
  assign root_o  = root_r;
  assign degen_o = degen_r;

endmodule

/* rtl/point_segment_distance_top.sv */
// channel  | ports                    | handshake
// input    | start, busy, in_data     | taken when start high and busy low
// result   | out_valid, out_data      | one-cycle strobe, cannot be held off
//
// one item per cycle, busy is never raised; the chain runs through stages 0 to 2,
// the 32 division cells, stages m1 to m3 and the 27 square-root cells.
// synchronous active-low reset clears the valid bits of every stage.
// the receiver cannot stall, so results leave the last cell as they arrive.
module point_segment_distance_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  psd_pkg::psd_in_t   in_data,
  output logic               out_valid,
  output psd_pkg::psd_out_t  out_data
);

  localparam int DW   = psd_pkg::DW;
  localparam int L2W  = psd_pkg::L2W;
  localparam int DOTW = psd_pkg::DOTW;
  localparam int TB   = psd_pkg::TB;
  localparam int EW   = psd_pkg::EW;
  localparam int SQW  = psd_pkg::SQW;
  localparam int PW   = DW + TB + 1;

  // stage 0: differences
  logic                 s0_vld_r;
  logic signed [DW-1:0] s0_abx_r, s0_aby_r, s0_apx_r, s0_apy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
    s0_abx_r <= DW'(in_data.end_x) - DW'(in_data.start_x);
    s0_aby_r <= DW'(in_data.end_y) - DW'(in_data.start_y);
    s0_apx_r <= DW'(in_data.point_x) - DW'(in_data.start_x);
    s0_apy_r <= DW'(in_data.point_y) - DW'(in_data.start_y);
  end

  // stage 1: squared length and dot product
  logic                   s1_vld_r;
  logic [L2W-1:0]         s1_len2_r;
  logic signed [DOTW-1:0] s1_dot_r;
  logic signed [DW-1:0]   s1_abx_r, s1_aby_r, s1_apx_r, s1_apy_r;
  logic signed [L2W-1:0]  len2_s;

  assign len2_s = L2W'(s0_abx_r) * L2W'(s0_abx_r) + L2W'(s0_aby_r) * L2W'(s0_aby_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_len2_r <= len2_s;
    s1_dot_r  <= DOTW'(s0_apx_r) * DOTW'(s0_abx_r) + DOTW'(s0_apy_r) * DOTW'(s0_aby_r);
    s1_abx_r  <= s0_abx_r;
    s1_aby_r  <= s0_aby_r;
    s1_apx_r  <= s0_apx_r;
    s1_apy_r  <= s0_apy_r;
  end

  // stage 2: clamp decisions, feeds the divider chain
  logic                 s2_vld_r;
  logic [L2W-1:0]       s2_rem_r, s2_den_r;
  psd_pkg::psd_dside_t  s2_side_r, s2_side_nxt;
  logic                 degen;

  always_comb begin
    degen              = (s1_len2_r == '0);
    s2_side_nxt.abx    = s1_abx_r;
    s2_side_nxt.aby    = s1_aby_r;
    s2_side_nxt.apx    = s1_apx_r;
    s2_side_nxt.apy    = s1_apy_r;
    s2_side_nxt.degen  = degen;
    // a zero-length segment is measured to the start point, as with t = 0
    s2_side_nxt.t_zero = degen | s1_dot_r[DOTW-1] | (s1_dot_r == '0);
    s2_side_nxt.t_one  = (s1_dot_r >= $signed({1'b0, s1_len2_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_rem_r  <= s1_dot_r[L2W-1:0];
    s2_den_r  <= s1_len2_r;
    s2_side_r <= s2_side_nxt;
  end

  // division chain
  logic                vld_d  [TB+1];
  logic [L2W-1:0]      rem_d  [TB+1];
  logic [L2W-1:0]      den_d  [TB+1];
  logic [TB-1:0]       quo_d  [TB+1];
  psd_pkg::psd_dside_t side_d [TB+1];

  assign vld_d[0]  = s2_vld_r;
  assign rem_d[0]  = s2_rem_r;
  assign den_d[0]  = s2_den_r;
  assign quo_d[0]  = '0;
  assign side_d[0] = s2_side_r;

  for (genvar k = 0; k < TB; k++) begin : g_div
    psd_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_d[k]),
      .rem_i  (rem_d[k]),
      .den_i  (den_d[k]),
      .quo_i  (quo_d[k]),
      .side_i (side_d[k]),
      .vld_o  (vld_d[k+1]),
      .rem_o  (rem_d[k+1]),
      .den_o  (den_d[k+1]),
      .quo_o  (quo_d[k+1]),
      .side_o (side_d[k+1])
    );
  end

  // m1: scale segment by t
  psd_pkg::psd_dside_t dv;
  logic [TB:0]         t_val;
  logic [DW-1:0]       magx, magy;
  logic                m1_vld_r, m1_degen_r, m1_negx_r, m1_negy_r;
  logic [PW-1:0]       m1_px_r, m1_py_r;
  logic signed [DW-1:0] m1_apx_r, m1_apy_r;

  always_comb begin
    dv = side_d[TB];
    if (dv.t_zero) begin
      t_val = '0;
    end else if (dv.t_one) begin
      t_val = {1'b1, {TB{1'b0}}};
    end else begin
      t_val = {1'b0, quo_d[TB]};
    end
    magx = dv.abx[DW-1] ? DW'(-dv.abx) : DW'(dv.abx);
    magy = dv.aby[DW-1] ? DW'(-dv.aby) : DW'(dv.aby);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= vld_d[TB];
    end
    m1_px_r    <= PW'(magx) * PW'(t_val);
    m1_py_r    <= PW'(magy) * PW'(t_val);
    m1_negx_r  <= dv.abx[DW-1];
    m1_negy_r  <= dv.aby[DW-1];
    m1_apx_r   <= dv.apx;
    m1_apy_r   <= dv.apy;
    m1_degen_r <= dv.degen;
  end

  // m2: round half away from zero, residual offset
  logic [PW-1:0]        rx, ry;
  logic signed [EW-1:0] qx, qy;
  logic                 m2_vld_r, m2_degen_r;
  logic signed [EW-1:0] m2_dx_r, m2_dy_r;

  always_comb begin
    rx = (m1_px_r + (PW'(1) << (TB - 1))) >> TB;
    ry = (m1_py_r + (PW'(1) << (TB - 1))) >> TB;
    qx = m1_negx_r ? -$signed(rx[EW-1:0]) : $signed(rx[EW-1:0]);
    qy = m1_negy_r ? -$signed(ry[EW-1:0]) : $signed(ry[EW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else begin
      m2_vld_r <= m1_vld_r;
    end
    m2_dx_r    <= EW'(m1_apx_r) - qx;
    m2_dy_r    <= EW'(m1_apy_r) - qy;
    m2_degen_r <= m1_degen_r;
  end

  // m3: squared distance
  logic           m3_vld_r, m3_degen_r;
  logic [SQW-1:0] m3_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else begin
      m3_vld_r <= m2_vld_r;
    end
    m3_n_r     <= SQW'(m2_dx_r) * SQW'(m2_dx_r) + SQW'(m2_dy_r) * SQW'(m2_dy_r);
    m3_degen_r <= m2_degen_r;
  end

  // square-root chain, two radicand bits per cell
  logic           vld_s   [EW+1];
  logic [SQW-1:0] rad_s   [EW+1];
  logic [SQW-1:0] root_s  [EW+1];
  logic           degen_s [EW+1];

  assign vld_s[0]   = m3_vld_r;
  assign rad_s[0]   = m3_n_r;
  assign root_s[0]  = '0;
  assign degen_s[0] = m3_degen_r;

  for (genvar k = 0; k < EW; k++) begin : g_sqrt
    psd_sqrt_cell #(
      .SHIFT (2 * (EW - 1 - k))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_i   (vld_s[k]),
      .rad_i   (rad_s[k]),
      .root_i  (root_s[k]),
      .degen_i (degen_s[k]),
      .vld_o   (vld_s[k+1]),
      .rad_o   (rad_s[k+1]),
      .root_o  (root_s[k+1]),
      .degen_o (degen_s[k+1])
    );
  end

  assign busy                = 1'b0;
  assign out_valid           = vld_s[EW];
  assign out_data.distance   = root_s[EW][psd_pkg::DISTW-1:0];
  assign out_data.degenerate = degen_s[EW];

endmodule
